// ===== sv/rfk_pkg.sv =====
package rfk_pkg;

  localparam int POS_W    = 20;
  localparam int STR_W    = 16;
  localparam int OUT_W    = 16;
  localparam int FRAC_W   = 8;
  localparam int SQ_W     = 2 * POS_W;
  localparam int RAD_W    = 2 * POS_W + 2 * FRAC_W;
  localparam int ROOT_W   = POS_W + FRAC_W;
  localparam int REM_W    = RAD_W + 1;
  localparam int DEN_W    = ROOT_W + POS_W;
  localparam int PRD_W    = POS_W + ROOT_W;
  localparam int NUM_W    = 64;
  localparam int QUO_W    = 16;
  localparam int NUM_SQRT = ROOT_W;
  localparam int NUM_DIV  = QUO_W;

  localparam int IN_DW    = 120;
  localparam int OUT_DW   = 2 * OUT_W;

  localparam int ST_SQ    = 1;
  localparam int ST_D2    = 2;
  localparam int ST_RT0   = 3;
  localparam int ST_GAP   = ST_RT0 + NUM_SQRT;
  localparam int ST_MX    = ST_GAP + 1;
  localparam int ST_MS    = ST_MX + 1;
  localparam int ST_RND   = ST_MS + 1;
  localparam int ST_OVF   = ST_RND + 1;
  localparam int ST_OUT   = ST_OVF + NUM_DIV + 1;
  localparam int NUM_ST   = ST_OUT + 1;

  localparam logic [OUT_W:0] MAG_NEG_MAX = 17'h08000;
  localparam logic [OUT_W:0] MAG_POS_MAX = 17'h07fff;
  localparam logic [OUT_W:0] MAG_OVF     = 17'h10000;

  typedef struct packed {
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    logic [POS_W-1:0] rr;
    logic [STR_W-1:0] mag_s;
    logic             neg_x;
    logic             neg_y;
    logic             neg_s;
    logic             hit;
  } carry_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_t;

endpackage

// ===== sv/radial_falloff_force_kernel.sv =====
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: centre_x, centre_y, reach, strength, particle_x, particle_y
// m_axis    out  tdata: push_x, push_y; tuser: inside_res
//
// One transfer per cycle in and out while m_axis is not stalled; data passes through
// squares, a 28-stage square root, falloff products and a 16-stage divider per axis.
// rst_ni clears the valid bits only; payload registers are not reset.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and a stalled output does not block input until the pipe is full.
module radial_falloff_force_kernel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // centre_x, centre_y, reach, strength, particle_x, particle_y, zero pad
  input  logic [rfk_pkg::IN_DW-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // push_x, push_y
  output logic [rfk_pkg::OUT_DW-1:0]   m_axis_tdata,
  // inside_res
  output logic                         m_axis_tuser
);

  localparam int NST = rfk_pkg::NUM_ST;

  logic [NST-1:0] vld_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NST-1];

  // stage 0: offsets and signs
  logic [rfk_pkg::POS_W-1:0] cx, cy, reach, px, py;
  logic [rfk_pkg::STR_W-1:0] strength;
  rfk_pkg::carry_t           carry_in;
  rfk_pkg::carry_t           carry_q [0:rfk_pkg::ST_OUT-1];

  assign cx       = s_axis_tdata[19:0];
  assign cy       = s_axis_tdata[39:20];
  assign reach    = s_axis_tdata[59:40];
  assign strength = s_axis_tdata[75:60];
  assign px       = s_axis_tdata[95:76];
  assign py       = s_axis_tdata[115:96];

  always_comb begin
    carry_in.neg_x = px < cx;
    carry_in.neg_y = py < cy;
    carry_in.ax    = carry_in.neg_x ? cx - px : px - cx;
    carry_in.ay    = carry_in.neg_y ? cy - py : py - cy;
    carry_in.rr    = reach;
    carry_in.neg_s = strength[rfk_pkg::STR_W-1];
    carry_in.mag_s = carry_in.neg_s ? -strength : strength;
    carry_in.hit   = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      carry_q[0] <= carry_in;
    end
  end

  // stage 1: squares
  logic [rfk_pkg::SQ_W-1:0] sq_x_q, sq_y_q, sq_r_q;

  always_ff @(posedge clk_i) begin
    if (en[rfk_pkg::ST_SQ]) begin
      sq_x_q <= rfk_pkg::SQ_W'(carry_q[0].ax) * rfk_pkg::SQ_W'(carry_q[0].ax);
      sq_y_q <= rfk_pkg::SQ_W'(carry_q[0].ay) * rfk_pkg::SQ_W'(carry_q[0].ay);
      sq_r_q <= rfk_pkg::SQ_W'(carry_q[0].rr) * rfk_pkg::SQ_W'(carry_q[0].rr);
    end
  end

  // stage 2: squared distance and range test
  logic [rfk_pkg::SQ_W:0]    d2;
  logic                      hit_d2;
  logic [rfk_pkg::RAD_W-1:0] rad_q;
  rfk_pkg::carry_t           carry_hit;

  assign d2     = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign hit_d2 = (d2 != '0) && (d2 < {1'b0, sq_r_q});

  always_comb begin
    carry_hit     = carry_q[rfk_pkg::ST_D2-1];
    carry_hit.hit = hit_d2;
  end

  always_ff @(posedge clk_i) begin
    if (en[rfk_pkg::ST_D2]) begin
      rad_q <= hit_d2 ? {d2[rfk_pkg::SQ_W-1:0], {(2 * rfk_pkg::FRAC_W){1'b0}}} : '0;
    end
  end

  genvar k;
  generate
    for (k = 1; k < rfk_pkg::ST_OUT; k++) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          carry_q[k] <= (k == rfk_pkg::ST_D2) ? carry_hit : carry_q[k-1];
        end
      end
    end
  endgenerate

  // square root, one result bit per stage
  logic [rfk_pkg::REM_W-1:0] rt_rem_q [0:rfk_pkg::NUM_SQRT-1];
  logic [rfk_pkg::REM_W-1:0] rt_res_q [0:rfk_pkg::NUM_SQRT-1];

  genvar j;
  generate
    for (j = 0; j < rfk_pkg::NUM_SQRT; j++) begin : g_root
      logic [rfk_pkg::REM_W-1:0] rem_in, res_in, rt_bit;
      logic [rfk_pkg::REM_W:0]   trial;
      if (j == 0) begin : g_first
        assign rem_in = {1'b0, rad_q};
        assign res_in = '0;
      end else begin : g_next
        assign rem_in = rt_rem_q[j-1];
        assign res_in = rt_res_q[j-1];
      end
      assign rt_bit = rfk_pkg::REM_W'(1) << (2 * (rfk_pkg::NUM_SQRT - 1 - j));
      assign trial  = {1'b0, res_in} + {1'b0, rt_bit};
      always_ff @(posedge clk_i) begin
        if (en[rfk_pkg::ST_RT0 + j]) begin
          if ({1'b0, rem_in} >= trial) begin
            rt_rem_q[j] <= rem_in - trial[rfk_pkg::REM_W-1:0];
            rt_res_q[j] <= (res_in >> 1) + rt_bit;
          end else begin
            rt_rem_q[j] <= rem_in;
            rt_res_q[j] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  // falloff gap and denominator
  logic [rfk_pkg::ROOT_W-1:0] root;
  logic [rfk_pkg::ROOT_W-1:0] gap_q;
  logic [rfk_pkg::DEN_W-1:0]  den_q [rfk_pkg::ST_GAP:rfk_pkg::ST_OUT-2];
  rfk_pkg::carry_t            cg;

  assign root = rt_res_q[rfk_pkg::NUM_SQRT-1][rfk_pkg::ROOT_W-1:0];
  assign cg   = carry_q[rfk_pkg::ST_GAP-1];

  always_ff @(posedge clk_i) begin
    if (en[rfk_pkg::ST_GAP]) begin
      gap_q                <= {cg.rr, {rfk_pkg::FRAC_W{1'b0}}} - root;
      den_q[rfk_pkg::ST_GAP] <= rfk_pkg::DEN_W'(root) * rfk_pkg::DEN_W'(cg.rr);
    end
  end

  generate
    for (k = rfk_pkg::ST_GAP + 1; k <= rfk_pkg::ST_OUT - 2; k++) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          den_q[k] <= den_q[k-1];
        end
      end
    end
  endgenerate

  // numerators
  logic [rfk_pkg::PRD_W-1:0] prx_q, pry_q;
  logic [rfk_pkg::NUM_W-1:0] nx_q, ny_q, nrx_q, nry_q;
  rfk_pkg::carry_t           cm, cs;

  assign cm = carry_q[rfk_pkg::ST_MX-1];
  assign cs = carry_q[rfk_pkg::ST_MS-1];

  always_ff @(posedge clk_i) begin
    if (en[rfk_pkg::ST_MX]) begin
      prx_q <= rfk_pkg::PRD_W'(cm.ax) * rfk_pkg::PRD_W'(gap_q);
      pry_q <= rfk_pkg::PRD_W'(cm.ay) * rfk_pkg::PRD_W'(gap_q);
    end
    if (en[rfk_pkg::ST_MS]) begin
      nx_q <= rfk_pkg::NUM_W'(prx_q) * rfk_pkg::NUM_W'(cs.mag_s);
      ny_q <= rfk_pkg::NUM_W'(pry_q) * rfk_pkg::NUM_W'(cs.mag_s);
    end
    if (en[rfk_pkg::ST_RND]) begin
      nrx_q <= nx_q + rfk_pkg::NUM_W'(den_q[rfk_pkg::ST_MS] >> 1);
      nry_q <= ny_q + rfk_pkg::NUM_W'(den_q[rfk_pkg::ST_MS] >> 1);
    end
  end

  // restoring divide, quotient limited to 16 bits plus overflow flag
  rfk_pkg::div_t dvx_q [0:rfk_pkg::NUM_DIV];
  rfk_pkg::div_t dvy_q [0:rfk_pkg::NUM_DIV];
  logic [rfk_pkg::NUM_W:0] den_top;

  assign den_top = {{(rfk_pkg::NUM_W + 1 - rfk_pkg::DEN_W){1'b0}}, den_q[rfk_pkg::ST_RND]}
                   << rfk_pkg::QUO_W;

  always_ff @(posedge clk_i) begin
    if (en[rfk_pkg::ST_OVF]) begin
      dvx_q[0].rem <= nrx_q;
      dvx_q[0].quo <= '0;
      dvx_q[0].ovf <= {1'b0, nrx_q} >= den_top;
      dvy_q[0].rem <= nry_q;
      dvy_q[0].quo <= '0;
      dvy_q[0].ovf <= {1'b0, nry_q} >= den_top;
    end
  end

  generate
    for (j = 1; j <= rfk_pkg::NUM_DIV; j++) begin : g_div
      logic [rfk_pkg::NUM_W-1:0] dsh;
      logic                      tx, ty;
      assign dsh = rfk_pkg::NUM_W'(den_q[rfk_pkg::ST_OVF + j - 1]) << (rfk_pkg::NUM_DIV - j);
      assign tx  = dvx_q[j-1].rem >= dsh;
      assign ty  = dvy_q[j-1].rem >= dsh;
      always_ff @(posedge clk_i) begin
        if (en[rfk_pkg::ST_OVF + j]) begin
          dvx_q[j].rem <= tx ? dvx_q[j-1].rem - dsh : dvx_q[j-1].rem;
          dvx_q[j].quo <= {dvx_q[j-1].quo[rfk_pkg::QUO_W-2:0], tx};
          dvx_q[j].ovf <= dvx_q[j-1].ovf;
          dvy_q[j].rem <= ty ? dvy_q[j-1].rem - dsh : dvy_q[j-1].rem;
          dvy_q[j].quo <= {dvy_q[j-1].quo[rfk_pkg::QUO_W-2:0], ty};
          dvy_q[j].ovf <= dvy_q[j-1].ovf;
        end
      end
    end
  endgenerate

  // sign and saturation
  function automatic logic [rfk_pkg::OUT_W-1:0] sat_push(rfk_pkg::div_t d, logic neg);
    logic [rfk_pkg::OUT_W:0] mag;
    logic [rfk_pkg::OUT_W:0] neg_v;
    mag = d.ovf ? rfk_pkg::MAG_OVF : {1'b0, d.quo};
    if (neg) begin
      if (mag > rfk_pkg::MAG_NEG_MAX) begin
        mag = rfk_pkg::MAG_NEG_MAX;
      end
      neg_v = -mag;
      return neg_v[rfk_pkg::OUT_W-1:0];
    end
    if (mag > rfk_pkg::MAG_POS_MAX) begin
      mag = rfk_pkg::MAG_POS_MAX;
    end
    return mag[rfk_pkg::OUT_W-1:0];
  endfunction

  logic [rfk_pkg::OUT_W-1:0] push_x_q, push_y_q;
  logic                      inside_q;
  rfk_pkg::carry_t           co;

  assign co = carry_q[rfk_pkg::ST_OUT-1];

  always_ff @(posedge clk_i) begin
    if (en[rfk_pkg::ST_OUT]) begin
      push_x_q <= co.hit ? sat_push(dvx_q[rfk_pkg::NUM_DIV], co.neg_x ^ co.neg_s) : '0;
      push_y_q <= co.hit ? sat_push(dvy_q[rfk_pkg::NUM_DIV], co.neg_y ^ co.neg_s) : '0;
      inside_q <= co.hit;
    end
  end

  assign m_axis_tdata = {push_y_q, push_x_q};
  assign m_axis_tuser = inside_q;

endmodule
